FILE: hdl/chdg_pkg.sv
// ----------------------------------------------------------------------------
// chdg_pkg: compass heading shared constants
// Angle formats, the arctangent table for the CORDIC stages and the turn
// constants used by the heading wrap.
// ----------------------------------------------------------------------------
package chdg_pkg;

    // CORDIC angle accumulator, 1/32768 degree units
    localparam int Z_WIDTH        = 25;
    localparam int ATAN_TABLE_LEN = 24;

    // heading and register widths
    localparam int HEADING_WIDTH = 16;
    localparam int DECL_WIDTH    = 16;
    localparam int OFFSET_WIDTH  = 17;
    localparam int ANGLE_WIDTH   = Z_WIDTH - 8;
    localparam int SUM_WIDTH     = 19;

    localparam int GUARD_BITS = 8;

    localparam int FULL_TURN = 46080;
    localparam int HALF_TURN = 23040;

    localparam logic signed [Z_WIDTH-1:0] QUARTER_FINE = 25'sd2949120;
    localparam logic signed [Z_WIDTH-1:0] ROUND_HALF   = 25'sd128;

    // atan(2^-i) in 1/32768 degree, rounded to nearest
    localparam logic signed [Z_WIDTH-1:0] ATAN_FINE [ATAN_TABLE_LEN] = '{
        25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
        25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
        25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
        25'sd458,     25'sd229,    25'sd115,    25'sd57,
        25'sd29,      25'sd14,     25'sd7,      25'sd4,
        25'sd2,       25'sd1,      25'sd0,      25'sd0
    };

    // APB register word addresses
    localparam logic ADDR_DECLINATION = 1'b0;
    localparam logic ADDR_OFFSET      = 1'b1;

endpackage

FILE: hdl/chdg_cordic_stage.sv
// ----------------------------------------------------------------------------
// chdg_cordic_stage: one registered CORDIC vectoring iteration
// Rotates the vector toward the positive x axis by atan(2^-SHIFT) and
// accumulates the angle; holds its item until the next stage takes it.
// ----------------------------------------------------------------------------
module chdg_cordic_stage #(
    parameter int DATA_WIDTH = 27,
    parameter int SHIFT      = 0,
    parameter logic signed [chdg_pkg::Z_WIDTH-1:0] ATAN_STEP = '0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [DATA_WIDTH-1:0]        up_x,
    input  logic signed [DATA_WIDTH-1:0]        up_y,
    input  logic signed [chdg_pkg::Z_WIDTH-1:0] up_z,
    input  logic                                up_zero,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output logic signed [DATA_WIDTH-1:0]        dn_x,
    output logic signed [DATA_WIDTH-1:0]        dn_y,
    output logic signed [chdg_pkg::Z_WIDTH-1:0] dn_z,
    output logic                                dn_zero
);

    logic                                valid_reg;
    logic signed [DATA_WIDTH-1:0]        x_reg;
    logic signed [DATA_WIDTH-1:0]        y_reg;
    logic signed [chdg_pkg::Z_WIDTH-1:0] z_reg;
    logic                                zero_reg;

    logic signed [DATA_WIDTH-1:0]        x_next;
    logic signed [DATA_WIDTH-1:0]        y_next;
    logic signed [chdg_pkg::Z_WIDTH-1:0] z_next;
    logic signed [DATA_WIDTH-1:0]        dx;
    logic signed [DATA_WIDTH-1:0]        dy;

    assign up_ready = ~valid_reg | dn_ready;

    always_comb
    begin
        dx = up_y >>> SHIFT;
        dy = up_x >>> SHIFT;
        if (up_y >= 0)
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + ATAN_STEP;
        end
        else
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= up_zero;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_zero  = zero_reg;

endmodule

FILE: hdl/compass_heading_atan2_unit.sv
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit: magnetometer compass heading
// Pipelined CORDIC atan2 of (field_x, field_y) plus declination, minus yaw
// offset, wrapped into [-180, 180) degrees in 1/128 degree units.
// ----------------------------------------------------------------------------
// Accepts one item per clock when not stalled, returns one heading per item,
// in order. Pipeline: quadrant pre-rotation register, a register per CORDIC
// iteration (CORDIC_STAGES, at most the atan table length), the rounding and
// declination/offset sum register, and the wrapped output register. Every
// stage holds its item under backpressure, so out_ready low stalls only full
// stages. Registers: 0x0 declination (16-bit signed), 0x4 heading_offset
// (17-bit signed), both in 1/128 degree; write them only while idle.
module compass_heading_atan2_unit #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]            field_x,
    input  logic signed [SAMPLE_WIDTH-1:0]            field_y,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [chdg_pkg::HEADING_WIDTH-1:0] heading
);

    localparam int DW = SAMPLE_WIDTH + chdg_pkg::GUARD_BITS + 3;
    localparam int NS = (CORDIC_STAGES > chdg_pkg::ATAN_TABLE_LEN)
                        ? chdg_pkg::ATAN_TABLE_LEN : CORDIC_STAGES;
    localparam int ZW = chdg_pkg::Z_WIDTH;
    localparam int HW = chdg_pkg::SUM_WIDTH;

    // ---------------- configuration registers ----------------
    logic signed [chdg_pkg::DECL_WIDTH-1:0]   decl_reg;
    logic signed [chdg_pkg::OFFSET_WIDTH-1:0] offset_reg;
    logic                                     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                chdg_pkg::ADDR_DECLINATION:
                    decl_reg <= pwdata[chdg_pkg::DECL_WIDTH-1:0];
                chdg_pkg::ADDR_OFFSET:
                    offset_reg <= pwdata[chdg_pkg::OFFSET_WIDTH-1:0];
                default:
                    decl_reg <= decl_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            chdg_pkg::ADDR_DECLINATION: prdata = 32'(decl_reg);
            chdg_pkg::ADDR_OFFSET:      prdata = 32'(offset_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- quadrant pre-rotation ----------------
    logic                  pre_valid_reg;
    logic signed [DW-1:0]  pre_x_reg;
    logic signed [DW-1:0]  pre_y_reg;
    logic signed [ZW-1:0]  pre_z_reg;
    logic                  pre_zero_reg;
    logic signed [DW-1:0]  xs;
    logic signed [DW-1:0]  ys;
    logic signed [DW-1:0]  pre_x_next;
    logic signed [DW-1:0]  pre_y_next;
    logic signed [ZW-1:0]  pre_z_next;

    logic                  ch_valid [NS+1];
    logic                  ch_ready [NS+1];
    logic signed [DW-1:0]  ch_x     [NS+1];
    logic signed [DW-1:0]  ch_y     [NS+1];
    logic signed [ZW-1:0]  ch_z     [NS+1];
    logic                  ch_zero  [NS+1];

    always_comb
    begin
        xs = {{(DW-SAMPLE_WIDTH-chdg_pkg::GUARD_BITS){field_x[SAMPLE_WIDTH-1]}},
              field_x, {chdg_pkg::GUARD_BITS{1'b0}}};
        ys = {{(DW-SAMPLE_WIDTH-chdg_pkg::GUARD_BITS){field_y[SAMPLE_WIDTH-1]}},
              field_y, {chdg_pkg::GUARD_BITS{1'b0}}};
        pre_x_next = xs;
        pre_y_next = ys;
        pre_z_next = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                pre_x_next = ys;
                pre_y_next = -xs;
                pre_z_next = chdg_pkg::QUARTER_FINE;
            end
            else
            begin
                pre_x_next = -ys;
                pre_y_next = xs;
                pre_z_next = -chdg_pkg::QUARTER_FINE;
            end
        end
    end

    assign in_ready = ~pre_valid_reg | ch_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_z_reg    <= pre_z_next;
            pre_zero_reg <= (field_x == '0) && (field_y == '0);
        end
    end

    assign ch_valid[0] = pre_valid_reg;
    assign ch_x[0]     = pre_x_reg;
    assign ch_y[0]     = pre_y_reg;
    assign ch_z[0]     = pre_z_reg;
    assign ch_zero[0]  = pre_zero_reg;

    // ---------------- CORDIC iterations ----------------
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        chdg_cordic_stage #(
            .DATA_WIDTH (DW),
            .SHIFT      (i),
            .ATAN_STEP  (chdg_pkg::ATAN_FINE[i])
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[i]),
            .up_ready (ch_ready[i]),
            .up_x     (ch_x[i]),
            .up_y     (ch_y[i]),
            .up_z     (ch_z[i]),
            .up_zero  (ch_zero[i]),
            .dn_valid (ch_valid[i+1]),
            .dn_ready (ch_ready[i+1]),
            .dn_x     (ch_x[i+1]),
            .dn_y     (ch_y[i+1]),
            .dn_z     (ch_z[i+1]),
            .dn_zero  (ch_zero[i+1])
        );
    end

    // ---------------- round, add declination, subtract offset ----------------
    logic                                    sum_valid_reg;
    logic                                    sum_ready;
    logic signed [HW-1:0]                    sum_reg;
    logic signed [ZW-1:0]                    z_round;
    logic signed [chdg_pkg::ANGLE_WIDTH-1:0] angle;
    logic signed [HW-1:0]                    sum_next;
    logic                                    out_stage_ready;

    always_comb
    begin
        z_round = ch_z[NS] + chdg_pkg::ROUND_HALF;
        angle   = ch_zero[NS] ? '0 : z_round[ZW-1:chdg_pkg::GUARD_BITS];
        sum_next = HW'(angle) + HW'(decl_reg) - HW'(offset_reg);
    end

    assign sum_ready  = ~sum_valid_reg | out_stage_ready;
    assign ch_ready[NS] = sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            sum_valid_reg <= ch_valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && ch_valid[NS])
        begin
            sum_reg <= sum_next;
        end
    end

    // ---------------- wrap into [-180, 180) ----------------
    logic                                     out_valid_reg;
    logic signed [chdg_pkg::HEADING_WIDTH-1:0] heading_reg;
    logic signed [HW-1:0]                     shifted;
    logic signed [HW-1:0]                     turn_sub;
    logic signed [HW-1:0]                     wrapped;

    // pick the largest multiple of a full turn not above sum + half turn
    always_comb
    begin
        shifted  = sum_reg + HW'(chdg_pkg::HALF_TURN);
        turn_sub = -$signed(HW'(3 * chdg_pkg::FULL_TURN));
        for (int m = -2; m <= 3; m++)
        begin
            if (shifted >= $signed(HW'(m * chdg_pkg::FULL_TURN)))
            begin
                turn_sub = $signed(HW'(m * chdg_pkg::FULL_TURN));
            end
        end
        wrapped = sum_reg - turn_sub;
    end

    assign out_stage_ready = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && sum_valid_reg)
        begin
            heading_reg <= wrapped[chdg_pkg::HEADING_WIDTH-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

endmodule
